FILE: hdl/hex_offset_grid_geometry_assert.svh
// assertion macros for the hex offset grid geometry unit
`ifndef HEX_OFFSET_GRID_GEOMETRY_ASSERT_SVH
`define HEX_OFFSET_GRID_GEOMETRY_ASSERT_SVH

// same-cycle implication
`define HOGG_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HOGG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/hogg_pkg.sv
// shared widths, codes and types for the hex offset grid geometry unit
`timescale 1ns / 1ps
`default_nettype none

package hogg_pkg;

    localparam int POS_W         = 14;
    localparam int DIST_W        = 8;
    localparam int DIR_W         = 3;
    localparam int SD_W          = 8;
    localparam int FUNC_W        = 2;
    localparam int GRID_W        = 7;
    localparam int COORD_W       = 7;
    localparam int CFG_IDX_W     = 1;
    localparam int POS_RADIX_DEF = 100;
    localparam int RECIP_SHIFT   = 22;

    localparam logic [FUNC_W-1:0] FUNC_NEIGHBOR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DISTANCE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DIRECTION = 2'd2;

    localparam logic [DIR_W-1:0] DIR_NONE = 3'd0;
    localparam logic [DIR_W-1:0] DIR_N    = 3'd1;
    localparam logic [DIR_W-1:0] DIR_NE   = 3'd2;
    localparam logic [DIR_W-1:0] DIR_SE   = 3'd3;
    localparam logic [DIR_W-1:0] DIR_S    = 3'd4;
    localparam logic [DIR_W-1:0] DIR_SW   = 3'd5;
    localparam logic [DIR_W-1:0] DIR_NW   = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GRID_COLUMNS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GRID_ROWS    = 1'd1;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } hogg_stage_en_t;

endpackage

`default_nettype wire

FILE: hdl/hogg_req_if.sv
// request channel of the hex offset grid geometry unit
`timescale 1ns / 1ps
`default_nettype none

interface hogg_req_if
    import hogg_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  first_pos;
    logic [POS_W-1:0]  second_pos;
    logic [SD_W-1:0]   step_dir;

    modport source (output valid, func, first_pos, second_pos, step_dir, input ready);
    modport sink (input valid, func, first_pos, second_pos, step_dir, output ready);
endinterface

`default_nettype wire

FILE: hdl/hogg_rsp_if.sv
// response channel of the hex offset grid geometry unit
`timescale 1ns / 1ps
`default_nettype none

interface hogg_rsp_if
    import hogg_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic              ok;
    logic [POS_W-1:0]  result_pos;
    logic [DIST_W-1:0] hex_distance;
    logic [DIR_W-1:0]  dir_code;

    modport source (output valid, ok, result_pos, hex_distance, dir_code, input ready);
    modport sink (input valid, ok, result_pos, hex_distance, dir_code, output ready);
endinterface

`default_nettype wire

FILE: hdl/hogg_cfg_if.sv
// register write channel of the hex offset grid geometry unit
`timescale 1ns / 1ps
`default_nettype none

interface hogg_cfg_if
    import hogg_pkg::*;
    ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [GRID_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/hogg_pos_split.sv
// three-stage split of a packed position into row and column with grid check
`timescale 1ns / 1ps
`default_nettype none

module hogg_pos_split
    import hogg_pkg::*;
#(
    parameter int POS_RADIX = POS_RADIX_DEF
) (
    input  wire logic                 clk,
    input  wire hogg_stage_en_t       en,
    input  wire logic [GRID_W-1:0]    grid_columns,
    input  wire logic [GRID_W-1:0]    grid_rows,
    input  wire logic [POS_W-1:0]     pos,
    output logic      [COORD_W-1:0]   row,
    output logic      [COORD_W-1:0]   col,
    output logic                      cell_ok
);

    localparam int RECIP   = (1 << RECIP_SHIFT) / POS_RADIX;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = POS_W + RECIP_W;
    localparam int ROW_W   = $clog2(((1 << POS_W) - 1) / POS_RADIX + 1);
    localparam int REM_W   = $clog2(2 * POS_RADIX);
    localparam int COL_W   = $clog2(POS_RADIX);
    localparam int CMP_W   = ROW_W + GRID_W;
    localparam int LIM_W   = GRID_W + 1;

    localparam logic [RECIP_W-1:0] RECIP_K   = RECIP_W'(RECIP);
    localparam logic [POS_W-1:0]   RADIX_POS = POS_W'(POS_RADIX);
    localparam logic [REM_W-1:0]   RADIX_REM = REM_W'(POS_RADIX);

    logic [POS_W-1:0]   s1_pos_reg;
    logic [PROD_W-1:0]  s1_prod_reg;
    logic [ROW_W-1:0]   s2_quo_reg;
    logic [REM_W-1:0]   s2_rem_reg;
    logic [COORD_W-1:0] s3_row_reg;
    logic [COORD_W-1:0] s3_col_reg;
    logic               s3_ok_reg;

    logic [PROD_W-1:0]  prod_next;
    logic [ROW_W-1:0]   quo_est;
    logic [POS_W-1:0]   quo_back;
    logic [POS_W-1:0]   rem_full;
    logic               fix;
    logic [ROW_W-1:0]   row_fix;
    logic [REM_W-1:0]   rem_fix;
    logic [COL_W-1:0]   col_fix;
    logic [LIM_W-1:0]   col_ext;
    logic               row_in;
    logic               col_in;

    // reciprocal multiply, then back-multiply, then one correction step
    always_comb
    begin
        prod_next = PROD_W'(pos) * PROD_W'(RECIP_K);
        quo_est   = ROW_W'(s1_prod_reg >> RECIP_SHIFT);
        quo_back  = POS_W'(POS_W'(quo_est) * RADIX_POS);
        rem_full  = s1_pos_reg - quo_back;
        fix       = (s2_rem_reg >= RADIX_REM);
        row_fix   = fix ? s2_quo_reg + ROW_W'(1) : s2_quo_reg;
        rem_fix   = fix ? s2_rem_reg - RADIX_REM : s2_rem_reg;
        col_fix   = rem_fix[COL_W-1:0];
        col_ext   = LIM_W'(col_fix);
        row_in    = CMP_W'(row_fix) < CMP_W'(grid_rows);
        if (row_fix[0])
        begin
            col_in = (col_ext + LIM_W'(1)) < LIM_W'(grid_columns);
        end
        else
        begin
            col_in = col_ext < LIM_W'(grid_columns);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            s1_pos_reg  <= pos;
            s1_prod_reg <= prod_next;
        end
        if (en.s2)
        begin
            s2_quo_reg <= quo_est;
            s2_rem_reg <= rem_full[REM_W-1:0];
        end
        if (en.s3)
        begin
            s3_row_reg <= COORD_W'(row_fix);
            s3_col_reg <= COORD_W'(col_fix);
            s3_ok_reg  <= row_in && col_in;
        end
    end

    assign row     = s3_row_reg;
    assign col     = s3_col_reg;
    assign cell_ok = s3_ok_reg;

endmodule

`default_nettype wire

FILE: hdl/hex_offset_grid_geometry.sv
// hex offset grid geometry unit: neighbor step, hex distance and direction code
// pipeline: 5 register stages, s1 to s5, lie between the accepted request and the registered result
// throughput: one request per cycle while rsp.ready does not stall the five-stage pipeline
// (three stages of reciprocal multiply split, one geometry stage, one result stage)
// reset clears all stage valid bits and both grid registers to 0
`timescale 1ns / 1ps
`default_nettype none
`include "hex_offset_grid_geometry_assert.svh"

module hex_offset_grid_geometry
    import hogg_pkg::*;
#(
    parameter int POS_RADIX = POS_RADIX_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    hogg_cfg_if.sink  cfg,
    hogg_req_if.sink  req,
    hogg_rsp_if.source rsp
);

    localparam int NB_W = COORD_W + 2;
    localparam logic [POS_W-1:0] RADIX_POS = POS_W'(POS_RADIX);

    logic [GRID_W-1:0] grid_columns_reg;
    logic [GRID_W-1:0] grid_rows_reg;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic en1, en2, en3, en4, en5;
    hogg_stage_en_t split_en;

    logic [FUNC_W-1:0] s1_func_reg, s2_func_reg, s3_func_reg, s4_func_reg;
    logic [DIR_W-1:0]  s1_dir_reg, s2_dir_reg, s3_dir_reg;
    logic              s1_sd_ok_reg, s2_sd_ok_reg, s3_sd_ok_reg;

    logic [COORD_W-1:0] ya, xa, yb, xb;
    logic               a_ok, b_ok;

    logic                     s4_nb_ok_reg;
    logic                     s4_pair_ok_reg;
    logic signed [NB_W-1:0]   s4_ny_reg;
    logic signed [NB_W-1:0]   s4_nx_reg;
    logic [DIST_W-1:0]        s4_dx_reg;
    logic [DIST_W-1:0]        s4_dy_reg;
    logic [DIR_W-1:0]         s4_code_reg;

    logic              ok_reg;
    logic [POS_W-1:0]  result_pos_reg;
    logic [DIST_W-1:0] hex_distance_reg;
    logic [DIR_W-1:0]  dir_code_reg;

    logic sd_ok_in;

    // stage 4 signals
    logic [COORD_W-1:0]     ax, ay;
    logic                   x_up, x_dn, par_diff, dx_inc, dx_dec;
    logic [DIST_W-1:0]      dx_next, dy_next;
    logic signed [NB_W-1:0] y9, x9, odd9, even9, ny_next, nx_next;
    logic [DIR_W-1:0]       code_raw;

    // stage 5 signals
    logic [NB_W-2:0]   ny_u, nx_u;
    logic              nb_cell_ok;
    logic [POS_W-1:0]  rpos;
    logic [DIST_W-1:0] dy2, dist_val;
    logic              ok_next;
    logic [POS_W-1:0]  rpos_next;
    logic [DIST_W-1:0] dist_next;
    logic [DIR_W-1:0]  code_next;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_columns_reg <= '0;
            grid_rows_reg    <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_IDX_GRID_COLUMNS: grid_columns_reg <= cfg.data;
                CFG_IDX_GRID_ROWS:    grid_rows_reg    <= cfg.data;
                default:              ;
            endcase
        end
    end

    // pipeline flow control
    assign en5 = !s5_valid_reg || rsp.ready;
    assign en4 = !s4_valid_reg || en5;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign req.ready = en1;

    assign split_en.s1 = en1;
    assign split_en.s2 = en2;
    assign split_en.s3 = en3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= req.valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (en5)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    // stages 1 to 3: position split
    hogg_pos_split #(
        .POS_RADIX (POS_RADIX)
    ) u_split_a (
        .clk          (clk),
        .en           (split_en),
        .grid_columns (grid_columns_reg),
        .grid_rows    (grid_rows_reg),
        .pos          (req.first_pos),
        .row          (ya),
        .col          (xa),
        .cell_ok      (a_ok)
    );

    hogg_pos_split #(
        .POS_RADIX (POS_RADIX)
    ) u_split_b (
        .clk          (clk),
        .en           (split_en),
        .grid_columns (grid_columns_reg),
        .grid_rows    (grid_rows_reg),
        .pos          (req.second_pos),
        .row          (yb),
        .col          (xb),
        .cell_ok      (b_ok)
    );

    assign sd_ok_in = (req.step_dir >= SD_W'(DIR_N)) && (req.step_dir <= SD_W'(DIR_NW));

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_func_reg  <= req.func;
            s1_dir_reg   <= req.step_dir[DIR_W-1:0];
            s1_sd_ok_reg <= sd_ok_in;
        end
        if (en2)
        begin
            s2_func_reg  <= s1_func_reg;
            s2_dir_reg   <= s1_dir_reg;
            s2_sd_ok_reg <= s1_sd_ok_reg;
        end
        if (en3)
        begin
            s3_func_reg  <= s2_func_reg;
            s3_dir_reg   <= s2_dir_reg;
            s3_sd_ok_reg <= s2_sd_ok_reg;
        end
    end

    // stage 4: neighbor coordinates, distance terms, direction code
    always_comb
    begin
        ax       = (xb >= xa) ? xb - xa : xa - xb;
        ay       = (yb >= ya) ? yb - ya : ya - yb;
        x_up     = xb > xa;
        x_dn     = xb < xa;
        par_diff = ya[0] ^ yb[0];
        dx_inc   = par_diff && (ya[0] ? x_dn : x_up);
        dx_dec   = par_diff && (ya[0] ? x_up : x_dn);
        dx_next  = {ax, 1'b0} + DIST_W'(dx_inc) - DIST_W'(dx_dec);
        dy_next  = (DIST_W'(ay) + DIST_W'(1)) >> 1;

        y9    = $signed({2'b00, ya});
        x9    = $signed({2'b00, xa});
        odd9  = $signed({{(NB_W-1){1'b0}}, ya[0]});
        even9 = $signed({{(NB_W-1){1'b0}}, !ya[0]});

        unique case (s3_dir_reg)
            DIR_N:
            begin
                nx_next = x9;
                ny_next = y9 - NB_W'(2);
            end
            DIR_NE:
            begin
                nx_next = x9 + odd9;
                ny_next = y9 - NB_W'(1);
            end
            DIR_SE:
            begin
                nx_next = x9 + odd9;
                ny_next = y9 + NB_W'(1);
            end
            DIR_S:
            begin
                nx_next = x9;
                ny_next = y9 + NB_W'(2);
            end
            DIR_SW:
            begin
                nx_next = x9 - even9;
                ny_next = y9 + NB_W'(1);
            end
            default:
            begin
                nx_next = x9 - even9;
                ny_next = y9 - NB_W'(1);
            end
        endcase

        if (xa == xb)
        begin
            if (ya < yb)
            begin
                code_raw = DIR_S;
            end
            else if (ya > yb)
            begin
                code_raw = DIR_N;
            end
            else
            begin
                code_raw = DIR_NONE;
            end
        end
        else if (ya == yb)
        begin
            if (xa < xb)
            begin
                code_raw = (ya != '0) ? DIR_NE : DIR_SE;
            end
            else
            begin
                code_raw = (ya != '0) ? DIR_NW : DIR_SW;
            end
        end
        else if (xa < xb)
        begin
            code_raw = (ya > yb) ? DIR_NE : DIR_SE;
        end
        else
        begin
            code_raw = (ya > yb) ? DIR_NW : DIR_SW;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_func_reg    <= s3_func_reg;
            s4_nb_ok_reg   <= s3_sd_ok_reg && a_ok;
            s4_pair_ok_reg <= a_ok && b_ok;
            s4_ny_reg      <= ny_next;
            s4_nx_reg      <= nx_next;
            s4_dx_reg      <= dx_next;
            s4_dy_reg      <= dy_next;
            s4_code_reg    <= (a_ok && b_ok) ? code_raw : DIR_NONE;
        end
    end

    // stage 5: neighbor grid check, packed position, final distance
    always_comb
    begin
        ny_u = s4_ny_reg[NB_W-2:0];
        nx_u = s4_nx_reg[NB_W-2:0];
        nb_cell_ok = !s4_ny_reg[NB_W-1] && !s4_nx_reg[NB_W-1]
                     && (ny_u < (NB_W-1)'(grid_rows_reg));
        if (ny_u[0])
        begin
            nb_cell_ok = nb_cell_ok
                         && ((nx_u + (NB_W-1)'(1)) < (NB_W-1)'(grid_columns_reg));
        end
        else
        begin
            nb_cell_ok = nb_cell_ok && (nx_u < (NB_W-1)'(grid_columns_reg));
        end
        rpos = POS_W'(POS_W'(ny_u) * RADIX_POS) + POS_W'(nx_u);

        dy2 = s4_dy_reg << 1;
        if (s4_dx_reg <= dy2)
        begin
            dist_val = s4_dx_reg + ((dy2 - s4_dx_reg) >> 1);
        end
        else
        begin
            dist_val = s4_dx_reg;
        end

        ok_next   = 1'b0;
        rpos_next = '0;
        dist_next = '0;
        code_next = DIR_NONE;
        case (s4_func_reg)
            FUNC_NEIGHBOR:
            begin
                ok_next   = s4_nb_ok_reg && nb_cell_ok;
                rpos_next = (s4_nb_ok_reg && nb_cell_ok) ? rpos : '0;
            end
            FUNC_DISTANCE:
            begin
                ok_next   = s4_pair_ok_reg;
                dist_next = s4_pair_ok_reg ? dist_val : '0;
            end
            FUNC_DIRECTION:
            begin
                ok_next   = s4_pair_ok_reg;
                code_next = s4_code_reg;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            ok_reg           <= ok_next;
            result_pos_reg   <= rpos_next;
            hex_distance_reg <= dist_next;
            dir_code_reg     <= code_next;
        end
    end

    assign rsp.valid        = s5_valid_reg;
    assign rsp.ok           = ok_reg;
    assign rsp.result_pos   = result_pos_reg;
    assign rsp.hex_distance = hex_distance_reg;
    assign rsp.dir_code     = dir_code_reg;

    // failed request carries all-zero fields
    `HOGG_ASSERT_IMPLY(a_fail_zero, clk, rst_n, rsp.valid && !rsp.ok, (rsp.result_pos == '0) && (rsp.hex_distance == '0) && (rsp.dir_code == DIR_NONE), "failed result has nonzero field")
    // only one result field is live per request
    `HOGG_ASSERT_IMPLY(a_one_field, clk, rst_n, rsp.valid && (rsp.result_pos != '0), (rsp.hex_distance == '0) && (rsp.dir_code == DIR_NONE), "more than one result field set")
    // direction code stays in range
    `HOGG_ASSERT_IMPLY(a_code_range, clk, rst_n, rsp.valid, rsp.dir_code <= DIR_NW, "direction code out of range")
    // request stall only with a full pipeline
    `HOGG_ASSERT_IMPLY(a_stall_full, clk, rst_n, !req.ready, s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg && s5_valid_reg, "request stalled with a bubble in the pipeline")
    // a stalled result is kept
    `HOGG_ASSERT_NEXT(a_hold_valid, clk, rst_n, s4_valid_reg && !en5, s5_valid_reg && s4_valid_reg, "pipeline item lost during stall")

endmodule

`default_nettype wire

FILE: dv/tb.sv
// self-checking testbench for the hex offset grid geometry unit
`timescale 1ns / 1ps

module tb;
    import hogg_pkg::*;

    localparam int POS_RADIX = POS_RADIX_DEF;
    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASE_ITEMS = 150;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  first_pos;
        logic [POS_W-1:0]  second_pos;
        logic [SD_W-1:0]   step_dir;
    } query_t;

    typedef struct {
        logic              ok;
        logic [POS_W-1:0]  result_pos;
        logic [DIST_W-1:0] hex_distance;
        logic [DIR_W-1:0]  dir_code;
    } answer_t;

    class grid_answer_board;
        int      columns;
        int      rows;
        int      errors;
        answer_t pending[$];

        function new();
            columns = 0;
            rows = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [GRID_W-1:0] val);
            if (idx == CFG_IDX_GRID_COLUMNS)
                columns = int'(val);
            else if (idx == CFG_IDX_GRID_ROWS)
                rows = int'(val);
        endfunction

        function bit on_grid(int row, int col);
            int lim;
            if (row < 0 || col < 0)
                return 1'b0;
            if (row >= rows)
                return 1'b0;
            lim = columns - (row & 1);
            return col < lim;
        endfunction

        function answer_t predict(query_t q);
            answer_t a;
            int      x1;
            int      y1;
            int      x2;
            int      y2;
            int      nx;
            int      ny;
            int      odd;
            int      dx;
            int      dy;
            int      r;
            a.ok = 1'b0;
            a.result_pos = '0;
            a.hex_distance = '0;
            a.dir_code = DIR_NONE;
            x1 = int'(q.first_pos) % POS_RADIX;
            y1 = int'(q.first_pos) / POS_RADIX;
            x2 = int'(q.second_pos) % POS_RADIX;
            y2 = int'(q.second_pos) / POS_RADIX;
            if (q.func == FUNC_NEIGHBOR)
            begin
                if (q.step_dir >= SD_W'(DIR_N) && q.step_dir <= SD_W'(DIR_NW)
                    && on_grid(y1, x1))
                begin
                    odd = y1 & 1;
                    nx = x1;
                    ny = y1;
                    case (q.step_dir[DIR_W-1:0])
                        DIR_N:   ny = y1 - 2;
                        DIR_NE:
                        begin
                            nx = x1 + odd;
                            ny = y1 - 1;
                        end
                        DIR_SE:
                        begin
                            nx = x1 + odd;
                            ny = y1 + 1;
                        end
                        DIR_S:   ny = y1 + 2;
                        DIR_SW:
                        begin
                            nx = x1 - (1 - odd);
                            ny = y1 + 1;
                        end
                        default:
                        begin
                            nx = x1 - (1 - odd);
                            ny = y1 - 1;
                        end
                    endcase
                    if (on_grid(ny, nx))
                    begin
                        r = ny * POS_RADIX + nx;
                        a.ok = 1'b1;
                        a.result_pos = r[POS_W-1:0];
                    end
                end
            end
            else if (q.func == FUNC_DISTANCE)
            begin
                if (on_grid(y1, x1) && on_grid(y2, x2))
                begin
                    dx = 2 * ((x2 > x1) ? x2 - x1 : x1 - x2);
                    dy = (((y2 > y1) ? y2 - y1 : y1 - y2) + 1) / 2;
                    if ((y1 & 1) != (y2 & 1))
                    begin
                        if ((y1 & 1) == 0)
                        begin
                            if (x2 < x1) dx--;
                            if (x2 > x1) dx++;
                        end
                        else
                        begin
                            if (x2 < x1) dx++;
                            if (x2 > x1) dx--;
                        end
                    end
                    if (dx <= dy * 2)
                        r = (dy * 2 - dx) / 2 + dx;
                    else
                        r = dx;
                    a.ok = 1'b1;
                    a.hex_distance = r[DIST_W-1:0];
                end
            end
            else if (q.func == FUNC_DIRECTION)
            begin
                if (on_grid(y1, x1) && on_grid(y2, x2))
                begin
                    a.ok = 1'b1;
                    if (x1 == x2)
                    begin
                        if (y1 < y2)
                            a.dir_code = DIR_S;
                        else if (y1 > y2)
                            a.dir_code = DIR_N;
                    end
                    else if (y1 == y2)
                    begin
                        if (x1 < x2)
                            a.dir_code = (y1 != 0) ? DIR_NE : DIR_SE;
                        else
                            a.dir_code = (y1 != 0) ? DIR_NW : DIR_SW;
                    end
                    else if (x1 < x2)
                        a.dir_code = (y1 > y2) ? DIR_NE : DIR_SE;
                    else
                        a.dir_code = (y1 > y2) ? DIR_NW : DIR_SW;
                end
            end
            return a;
        endfunction

        function void note_query(query_t q);
            pending.push_back(predict(q));
        endfunction

        function void flag(string field, int want, int got);
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        endfunction

        function void check_answer(answer_t got);
            answer_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: ok %0d pos %0d dist %0d dir %0d",
                         $time, got.ok, got.result_pos, got.hex_distance, got.dir_code);
                return;
            end
            want = pending.pop_front();
            if (got.ok !== want.ok)
                flag("ok", int'(want.ok), int'(got.ok));
            if (got.result_pos !== want.result_pos)
                flag("result_pos", int'(want.result_pos), int'(got.result_pos));
            if (got.hex_distance !== want.hex_distance)
                flag("hex_distance", int'(want.hex_distance), int'(got.hex_distance));
            if (got.dir_code !== want.dir_code)
                flag("dir_code", int'(want.dir_code), int'(got.dir_code));
        endfunction

        function int pending_count();
            return pending.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   steady;
    int   cur_cols;
    int   cur_rows;
    int   cycle_count;

    grid_answer_board board;
    answer_t          seen;

    hogg_cfg_if cfg_ch ();
    hogg_req_if req_ch ();
    hogg_rsp_if rsp_ch ();

    hex_offset_grid_geometry #(
        .POS_RADIX(POS_RADIX)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg_ch),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        steady = 1'b0;
        cur_cols = 0;
        cur_rows = 0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_IDX_GRID_COLUMNS;
        cfg_ch.data = '0;
        req_ch.valid = 1'b0;
        req_ch.func = FUNC_NEIGHBOR;
        req_ch.first_pos = '0;
        req_ch.second_pos = '0;
        req_ch.step_dir = '0;
        rsp_ch.ready = 1'b0;
        board = new();
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        rsp_ch.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 30);

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready)
        begin
            seen.ok = rsp_ch.ok;
            seen.result_pos = rsp_ch.result_pos;
            seen.hex_distance = rsp_ch.hex_distance;
            seen.dir_code = rsp_ch.dir_code;
            board.check_answer(seen);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic query_t mk(logic [FUNC_W-1:0] func, int p1, int p2, int sd);
        query_t q;
        q.func = func;
        q.first_pos = p1[POS_W-1:0];
        q.second_pos = p2[POS_W-1:0];
        q.step_dir = sd[SD_W-1:0];
        return q;
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        int row;
        int col;
        int lim;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15 || cur_rows == 0 || cur_cols == 0)
            return POS_W'($urandom_range(0, 16383));
        if (roll < 30)
        begin
            // corners and borders, on or just off the grid
            case ($urandom_range(0, 4))
                0:       row = 0;
                1:       row = 1;
                2:       row = cur_rows - 2;
                3:       row = cur_rows - 1;
                default: row = cur_rows;
            endcase
            if (row < 0)
                row = 0;
            lim = cur_cols - (row & 1);
            case ($urandom_range(0, 2))
                0:       col = 0;
                1:       col = lim - 1;
                default: col = lim;
            endcase
            if (col < 0)
                col = 0;
            if (col > POS_RADIX - 1)
                col = POS_RADIX - 1;
            return POS_W'(row * POS_RADIX + col);
        end
        row = $urandom_range(0, cur_rows - 1);
        if (cur_cols == 1)
            row = row & ~1;
        lim = cur_cols - (row & 1);
        if (lim > POS_RADIX)
            lim = POS_RADIX;
        col = $urandom_range(0, lim - 1);
        return POS_W'(row * POS_RADIX + col);
    endfunction

    task automatic send_query(input query_t q);
        while (!steady && $urandom_range(0, 99) < 30)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func <= q.func;
        req_ch.first_pos <= q.first_pos;
        req_ch.second_pos <= q.second_pos;
        req_ch.step_dir <= q.step_dir;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        board.note_query(q);
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        query_t q;
        int     roll;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                q.func = FUNC_UNUSED;
            else if (roll < 40)
                q.func = FUNC_NEIGHBOR;
            else if (roll < 70)
                q.func = FUNC_DISTANCE;
            else
                q.func = FUNC_DIRECTION;
            q.first_pos = pick_pos();
            q.second_pos = pick_pos();
            if ($urandom_range(0, 99) < 85)
                q.step_dir = SD_W'($urandom_range(DIR_N, DIR_NW));
            else
                q.step_dir = SD_W'($urandom_range(0, 255));
            send_query(q);
        end
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending_count() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic configure(input int cols, input int rows);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_IDX_GRID_COLUMNS;
        cfg_ch.data <= cols[GRID_W-1:0];
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        board.set_reg(CFG_IDX_GRID_COLUMNS, cols[GRID_W-1:0]);
        @(negedge clk);
        cfg_ch.index <= CFG_IDX_GRID_ROWS;
        cfg_ch.data <= rows[GRID_W-1:0];
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        board.set_reg(CFG_IDX_GRID_ROWS, rows[GRID_W-1:0]);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        cur_cols = cols;
        cur_rows = rows;
    endtask

    initial
    begin
        int phase_cols [10];
        int phase_rows [10];
        int cols;
        int rows;
        phase_cols = '{1, 100, 127, 1, 100, 2, 3, 0, 50, 0};
        phase_rows = '{1, 100, 127, 100, 1, 3, 2, 50, 0, 0};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset grid: every position is off the grid
        send_random(20);
        drain();

        configure(100, 100);
        send_query(mk(FUNC_NEIGHBOR, 505, 0, DIR_N));
        send_query(mk(FUNC_NEIGHBOR, 505, 0, DIR_NE));
        send_query(mk(FUNC_NEIGHBOR, 505, 0, DIR_SE));
        send_query(mk(FUNC_NEIGHBOR, 505, 0, DIR_S));
        send_query(mk(FUNC_NEIGHBOR, 505, 0, DIR_SW));
        send_query(mk(FUNC_NEIGHBOR, 505, 0, DIR_NW));
        send_query(mk(FUNC_NEIGHBOR, 404, 0, DIR_NE));
        send_query(mk(FUNC_NEIGHBOR, 404, 0, DIR_SE));
        send_query(mk(FUNC_NEIGHBOR, 404, 0, DIR_SW));
        send_query(mk(FUNC_NEIGHBOR, 404, 0, DIR_NW));
        send_query(mk(FUNC_NEIGHBOR, 0, 0, DIR_N));
        send_query(mk(FUNC_NEIGHBOR, 505, 0, 0));
        send_query(mk(FUNC_NEIGHBOR, 505, 9999, 255));
        send_query(mk(FUNC_NEIGHBOR, 9899, 0, DIR_S));
        send_query(mk(FUNC_NEIGHBOR, 9899, 0, DIR_NE));
        send_query(mk(FUNC_NEIGHBOR, 16383, 0, DIR_N));
        send_query(mk(FUNC_DISTANCE, 0, 9899, 0));
        send_query(mk(FUNC_DISTANCE, 9899, 0, 255));
        send_query(mk(FUNC_DISTANCE, 505, 505, 0));
        send_query(mk(FUNC_DISTANCE, 0, 9999, 0));
        send_query(mk(FUNC_DIRECTION, 0, 5, 0));
        send_query(mk(FUNC_DIRECTION, 5, 0, 0));
        send_query(mk(FUNC_DIRECTION, 505, 510, 0));
        send_query(mk(FUNC_DIRECTION, 505, 505, 0));
        send_query(mk(FUNC_DIRECTION, 9899, 99, 0));
        send_query(mk(FUNC_UNUSED, 505, 506, DIR_N));
        drain();

        for (int p = 0; p < 10; p++)
        begin
            cols = phase_cols[p];
            rows = phase_rows[p];
            if (p == 9)
            begin
                cols = $urandom_range(1, 100);
                rows = $urandom_range(1, 100);
            end
            configure(cols, rows);
            steady = (p == 1);
            send_random(PHASE_ITEMS);
            drain();
            steady = 1'b0;
        end

        repeat (10) @(posedge clk);
        if (board.errors == 0 && board.pending_count() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
